### rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// shared constants and types of the closed tour length unit
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int CTL_COORD_BITS = 16;
    localparam int CTL_FRAC_BITS  = 8;
    localparam int SUM_BITS       = 35;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef enum logic [0:0] {
        REG_START_X = 1'b0,
        REG_START_Y = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_ROOT,
        S_EMIT
    } state_t;

endpackage

### rtl/ctl_sqdist.sv
// ----------------------------------------------------------------------------
// ctl_sqdist
// bit-serial squared distance, one multiplier bit of dx and dy per cycle
// ----------------------------------------------------------------------------
module ctl_sqdist
    import ctl_pkg::*;
#(
    parameter int COORD_BITS = CTL_COORD_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    output logic                        done,
    output logic [2*COORD_BITS:0]       sq
);

    localparam int PW = 2 * COORD_BITS;
    localparam int CW = $clog2(COORD_BITS);

    logic signed [COORD_BITS:0] dx_diff, dy_diff;
    logic [COORD_BITS:0]        dx_mag, dy_mag;
    logic [PW-1:0]              mx_reg, my_reg;
    logic [COORD_BITS-1:0]      qx_reg, qy_reg;
    logic [PW:0]                acc_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    assign dx_diff = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    assign dy_diff = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    assign dx_mag  = dx_diff[COORD_BITS] ? -dx_diff : dx_diff;
    assign dy_mag  = dy_diff[COORD_BITS] ? -dy_diff : dy_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(COORD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath, multiplicand moves left, multiplier moves right
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mx_reg  <= PW'(dx_mag[COORD_BITS-1:0]);
            my_reg  <= PW'(dy_mag[COORD_BITS-1:0]);
            qx_reg  <= dx_mag[COORD_BITS-1:0];
            qy_reg  <= dy_mag[COORD_BITS-1:0];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + (qx_reg[0] ? {1'b0, mx_reg} : '0)
                               + (qy_reg[0] ? {1'b0, my_reg} : '0);
            mx_reg  <= {mx_reg[PW-2:0], 1'b0};
            my_reg  <= {my_reg[PW-2:0], 1'b0};
            qx_reg  <= {1'b0, qx_reg[COORD_BITS-1:1]};
            qy_reg  <= {1'b0, qy_reg[COORD_BITS-1:1]};
        end
    end

    assign done = done_reg;
    assign sq   = acc_reg;

endmodule

### rtl/ctl_isqrt.sv
// ----------------------------------------------------------------------------
// ctl_isqrt
// restoring floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module ctl_isqrt
    import ctl_pkg::*;
#(
    parameter int ROOT_BITS = CTL_COORD_BITS + CTL_FRAC_BITS + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [2*ROOT_BITS-1:0] radicand,
    output logic                   done,
    output logic [ROOT_BITS-1:0]   root
);

    localparam int RAD_BITS = 2 * ROOT_BITS;
    localparam int REM_W    = ROOT_BITS + 3;
    localparam int CW       = $clog2(ROOT_BITS);

    logic [RAD_BITS-1:0]  rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ROOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/closed_tour_length_unit.sv
// ----------------------------------------------------------------------------
// closed_tour_length_unit
// fixed point length of a closed euclidean tour through a configured start
// ----------------------------------------------------------------------------
// points arrive on the input channel (in_valid / in_stall), one request per
// point, with last_point set on the final point of a tour. every tour starts
// and ends at start_x / start_y; the user writes them through cfg_write /
// cfg_index / cfg_data only while the unit is idle, which the block itself
// does not enforce. one result per tour leaves on the output channel
// (out_valid / out_stall): the sum of segment lengths with FRAC_BITS
// fraction bits, saturating at the top of its 35 bits. each segment passes
// through the bit-serial squarer and then the square root, and the last
// point of a tour adds the closing segment back to the start. in_stall is
// high while a point is in work. a finished result sits in the output
// register until taken; the next point is accepted meanwhile, and the
// following tour total waits for the register to free up. reset clears the
// running sum, the start point and the output valid flag and arms the unit
// for the first point of a tour.
// ----------------------------------------------------------------------------
module closed_tour_length_unit
    import ctl_pkg::*;
#(
    parameter int COORD_BITS = CTL_COORD_BITS,
    parameter int FRAC_BITS  = CTL_FRAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [SUM_BITS-1:0]          tour_length
);

    localparam int ROOT_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int ACC_W     = (ROOT_BITS > SUM_BITS ? ROOT_BITS : SUM_BITS) + 1;

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] start_x_reg, start_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic                         first_reg, first_next;
    logic                         last_reg, last_next;
    logic                         seg_b_reg, seg_b_next;
    logic [SUM_BITS-1:0]          sum_reg, sum_next;
    logic                         out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]          out_data_reg, out_data_next;

    logic                         dist_go, root_go;
    logic                         sq_done, root_done;
    logic signed [COORD_BITS-1:0] op_ax, op_ay, op_bx, op_by;
    logic [SQ_BITS-1:0]           sq;
    logic [ROOT_BITS-1:0]         seg_len;
    logic [ACC_W-1:0]             sum_wide;
    logic [SUM_BITS-1:0]          sum_sat;
    logic                         accept;
    logic                         out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // first segment from start or previous point, closing segment back to start
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            op_ax = first_reg ? start_x_reg : prev_x_reg;
            op_ay = first_reg ? start_y_reg : prev_y_reg;
            op_bx = point_x;
            op_by = point_y;
        end
        else
        begin
            op_ax = prev_x_reg;
            op_ay = prev_y_reg;
            op_bx = start_x_reg;
            op_by = start_y_reg;
        end
    end

    assign sum_wide = ACC_W'(sum_reg) + ACC_W'(seg_len);
    assign sum_sat  = (sum_wide >= ACC_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                default:     start_x_reg <= start_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            first_reg     <= 1'b1;
            last_reg      <= 1'b0;
            seg_b_reg     <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            seg_b_reg     <= seg_b_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        seg_b_next     = seg_b_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        dist_go        = 1'b0;
        root_go        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dist_go     = 1'b1;
                    prev_x_next = point_x;
                    prev_y_next = point_y;
                    first_next  = 1'b0;
                    last_next   = last_point;
                    seg_b_next  = 1'b0;
                    state_next  = S_DIST;
                end
            end
            S_DIST:
            begin
                if (sq_done)
                begin
                    root_go    = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    sum_next = sum_sat;
                    if (last_reg && !seg_b_reg)
                    begin
                        dist_go    = 1'b1;
                        seg_b_next = 1'b1;
                        state_next = S_DIST;
                    end
                    else if (last_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_data_next  = sum_reg;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    first_next     = 1'b1;
                    last_next      = 1'b0;
                    seg_b_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ctl_sqdist #(
        .COORD_BITS (COORD_BITS)
    ) u_sqdist (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (dist_go),
        .ax    (op_ax),
        .ay    (op_ay),
        .bx    (op_bx),
        .by    (op_by),
        .done  (sq_done),
        .sq    (sq)
    );

    ctl_isqrt #(
        .ROOT_BITS (ROOT_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (root_go),
        .radicand (RAD_BITS'(sq) << (2 * FRAC_BITS)),
        .done     (root_done),
        .root     (seg_len)
    );

    assign out_valid   = out_valid_reg;
    assign tour_length = out_data_reg;

    a_sq_done_in_dist: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == S_DIST)
        else $error("squarer finished outside the distance phase");

    a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == S_ROOT)
        else $error("square root finished outside the root phase");

    a_closing_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        seg_b_reg |-> last_reg)
        else $error("closing segment started on a point that is not last");

    a_rearm_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=>
            (sum_reg == '0 && first_reg && out_valid_reg && state_reg == S_IDLE))
        else $error("tour total sent without re-arming");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// closed tour length unit: random tours checked against a behavioral predictor
// ----------------------------------------------------------------------------
// points are queued by the stimulus process and sent in random bursts; every
// accepted request advances a local copy of the tour state, and each tour
// total that should come out is queued and compared on the output channel.
// the start point is rewritten between phases, including once mid-tour, and
// one tour runs long enough to pin the sum at its ceiling. the receiver
// stalls on its own pattern and once holds off long enough to back up the
// input side.
// ----------------------------------------------------------------------------
module testbench;
    import ctl_pkg::*;

    localparam int CW          = CTL_COORD_BITS;
    localparam int REST_CYCLES = 200;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SAT_POINTS  = 1460;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 is_last;
    } tour_point_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_write  = 1'b0;
    logic                 cfg_index  = REG_START_X;
    logic [CW-1:0]        cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic signed [CW-1:0] point_x    = '0;
    logic signed [CW-1:0] point_y    = '0;
    logic                 last_point = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [SUM_BITS-1:0]  tour_length;

    tour_point_t          point_queue[$];
    logic [SUM_BITS-1:0]  length_queue[$];

    logic signed [CW-1:0] start_x_cfg = '0;
    logic signed [CW-1:0] start_y_cfg = '0;
    logic signed [CW-1:0] tour_prev_x = '0;
    logic signed [CW-1:0] tour_prev_y = '0;
    logic [63:0]          tour_sum    = '0;
    logic                 tour_fresh  = 1'b1;

    int                   mismatches  = 0;
    logic                 hold_req    = 1'b0;

    closed_tour_length_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tour_length (tour_length)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] segment_length(input logic signed [CW-1:0] ax,
                                                   input logic signed [CW-1:0] ay,
                                                   input logic signed [CW-1:0] bx,
                                                   input logic signed [CW-1:0] by);
        longint      dx;
        longint      dy;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] digit;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        rem  = 64'(dx * dx + dy * dy) << (2 * CTL_FRAC_BITS);
        root = '0;
        // floor square root, one result bit per pass
        for (int i = 31; i >= 0; i--)
        begin
            digit = 64'd1 << (2 * i);
            if (rem >= root + digit)
            begin
                rem  = rem - (root + digit);
                root = (root >> 1) + digit;
            end
            else
            begin
                root = root >> 1;
            end
        end
        return root;
    endfunction

    function automatic logic [63:0] saturating_sum(input logic [63:0] sum,
                                                   input logic [63:0] seg);
        if (seg >= 64'(SUM_MAX) - sum)
        begin
            return 64'(SUM_MAX);
        end
        return sum + seg;
    endfunction

    function automatic void advance_tour(input tour_point_t p);
        logic [63:0] seg;
        if (tour_fresh)
        begin
            seg = segment_length(start_x_cfg, start_y_cfg, p.x, p.y);
        end
        else
        begin
            seg = segment_length(tour_prev_x, tour_prev_y, p.x, p.y);
        end
        tour_sum    = saturating_sum(tour_sum, seg);
        tour_prev_x = p.x;
        tour_prev_y = p.y;
        tour_fresh  = 1'b0;
        if (p.is_last)
        begin
            seg      = segment_length(p.x, p.y, start_x_cfg, start_y_cfg);
            tour_sum = saturating_sum(tour_sum, seg);
            length_queue.push_back(tour_sum[SUM_BITS-1:0]);
            tour_sum   = '0;
            tour_fresh = 1'b1;
        end
    endfunction

    // driver
    tour_point_t cur_point;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_tour(cur_point);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (point_queue.size() != 0)
                begin
                    cur_point = point_queue.pop_front();
                    point_x    <= cur_point.x;
                    point_y    <= cur_point.y;
                    last_point <= cur_point.is_last;
                    in_valid   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int pattern_left = 0;
    int stall_mode   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(16, 200);
                stall_mode   = $urandom_range(0, 3);
            end
            else
            begin
                pattern_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // monitor
    logic [SUM_BITS-1:0] want_length;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (length_queue.size() == 0)
            begin
                $display("%0t: unexpected tour length, expected none, actual %0d",
                         $time, tour_length);
                mismatches++;
            end
            else
            begin
                want_length = length_queue.pop_front();
                if (tour_length !== want_length)
                begin
                    $display("%0t: tour_length mismatch, expected %0d, actual %0d",
                             $time, want_length, tour_length);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic is_last);
        tour_point_t p;
        p.x       = x;
        p.y       = y;
        p.is_last = is_last;
        point_queue.push_back(p);
    endtask

    function automatic logic signed [CW-1:0] pick_coord(input logic signed [CW-1:0] center);
        case ($urandom_range(0, 9))
            6, 7:
            begin
                case ($urandom_range(0, 6))
                    0: return CW'(-32768);
                    1: return CW'(-32767);
                    2: return CW'(-1);
                    3: return CW'(0);
                    4: return CW'(1);
                    5: return CW'(32766);
                    default: return CW'(32767);
                endcase
            end
            8, 9: return center + CW'($urandom_range(0, 128)) - CW'(64);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic add_tour(input int n);
        for (int i = 0; i < n; i++)
        begin
            add_point(pick_coord(start_x_cfg), pick_coord(start_y_cfg), i == n - 1);
        end
    endtask

    // wait until the block has gone quiet
    task automatic drain_and_rest();
        @(negedge clk);
        while (point_queue.size() != 0 || in_valid || length_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (REST_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_start(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        @(posedge clk);
        cfg_write   <= 1'b1;
        cfg_index   <= REG_START_X;
        cfg_data    <= x;
        start_x_cfg = x;
        @(posedge clk);
        cfg_index   <= REG_START_Y;
        cfg_data    <= y;
        start_y_cfg = y;
        @(posedge clk);
        cfg_write   <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int count;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-point tours and one four-point tour from the reset start
        add_point(CW'(32767), CW'(32767), 1'b1);
        add_point(CW'(-32768), CW'(-32768), 1'b1);
        add_point(CW'(0), CW'(0), 1'b1);
        add_point(CW'(-32768), CW'(32767), 1'b0);
        add_point(CW'(32767), CW'(-32768), 1'b0);
        add_point(CW'(-32768), CW'(-32768), 1'b0);
        add_point(CW'(32767), CW'(32767), 1'b1);
        drain_and_rest();

        set_start(CW'(-32768), CW'(-32768));
        add_point(CW'(32767), CW'(32767), 1'b1);
        add_point(CW'(32767), CW'(-32768), 1'b0);
        add_point(CW'(-32768), CW'(32767), 1'b1);
        drain_and_rest();

        set_start(CW'(32767), CW'(-1));
        add_point(CW'(-1), CW'(32767), 1'b0);
        add_point(CW'(0), CW'(0), 1'b0);
        add_point(CW'(32767), CW'(-1), 1'b1);
        drain_and_rest();

        // start moved in the middle of a tour
        set_start(CW'(100), CW'(-200));
        add_point(CW'(5), CW'(7), 1'b0);
        drain_and_rest();
        set_start(CW'(-300), CW'(400));
        add_point(CW'(-1), CW'(-1), 1'b1);
        drain_and_rest();

        // long output hold-off while short tours keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            add_tour(1);
        end
        drain_and_rest();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_start(CW'(32767), CW'(-32768));
                1: set_start(CW'(-32768), CW'(32767));
                default: set_start(CW'($urandom), CW'($urandom));
            endcase
            count = 0;
            while (count < 24)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
                add_tour(n);
                count += n;
            end
            drain_and_rest();
        end

        // segments between opposite corners until the sum saturates, then a short random tour
        set_start(CW'(-32768), CW'(-32768));
        for (int i = 0; i < SAT_POINTS; i++)
        begin
            if (i % 2 == 0)
            begin
                add_point(CW'(32767), CW'(32767), i == SAT_POINTS - 1);
            end
            else
            begin
                add_point(CW'(-32768), CW'(-32768), i == SAT_POINTS - 1);
            end
        end
        add_tour(3);
        drain_and_rest();

        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
